// File: rtl/core/cst_pkg.sv
// Package for the character stream tokenizer: token codes, scanner state codes,
// the keyword table and the character-class helper functions. Has no dependencies.
package cst_pkg;

    // Token codes.
    localparam logic [5:0] TK_ERROR = 6'd0;
    localparam logic [5:0] TK_IDENT = 6'd1;
    localparam logic [5:0] TK_COMMENT = 6'd2;
    localparam logic [5:0] TK_LPAREN = 6'd3;
    localparam logic [5:0] TK_RPAREN = 6'd4;
    localparam logic [5:0] TK_LBRACE = 6'd5;
    localparam logic [5:0] TK_RBRACE = 6'd6;
    localparam logic [5:0] TK_SEMI = 6'd7;
    localparam logic [5:0] TK_ASSIGN = 6'd8;
    localparam logic [5:0] TK_NE = 6'd9;
    localparam logic [5:0] TK_COMMA = 6'd10;
    localparam logic [5:0] TK_EQ = 6'd11;
    localparam logic [5:0] TK_GT = 6'd12;
    localparam logic [5:0] TK_GE = 6'd13;
    localparam logic [5:0] TK_LT = 6'd14;
    localparam logic [5:0] TK_LE = 6'd15;
    localparam logic [5:0] TK_HEX = 6'd16;
    localparam logic [5:0] TK_CHAR = 6'd17;
    localparam logic [5:0] TK_PLUS = 6'd18;
    localparam logic [5:0] TK_MINUS = 6'd19;
    localparam logic [5:0] TK_STAR = 6'd20;
    localparam logic [5:0] TK_SLASH = 6'd21;
    localparam logic [5:0] TK_OROR = 6'd22;
    localparam logic [5:0] TK_ANDAND = 6'd23;
    localparam logic [5:0] TK_EOS = 6'd24;
    localparam logic [5:0] TK_KW_BASE = 6'd25;

    // Scanner states.
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_EQ = 5'd1;
    localparam logic [4:0] ST_BANG = 5'd2;
    localparam logic [4:0] ST_GT = 5'd3;
    localparam logic [4:0] ST_LT = 5'd4;
    localparam logic [4:0] ST_AMP = 5'd5;
    localparam logic [4:0] ST_BAR = 5'd6;
    localparam logic [4:0] ST_SLASH = 5'd7;
    localparam logic [4:0] ST_BLOCK = 5'd8;
    localparam logic [4:0] ST_BSTAR = 5'd9;
    localparam logic [4:0] ST_LINE = 5'd10;
    localparam logic [4:0] ST_ZERO = 5'd11;
    localparam logic [4:0] ST_HEX0 = 5'd12;
    localparam logic [4:0] ST_HEXN = 5'd13;
    localparam logic [4:0] ST_IDENT = 5'd14;
    localparam logic [4:0] ST_CH1 = 5'd15;
    localparam logic [4:0] ST_CH2 = 5'd16;

    localparam logic [7:0] CH_QUOTE = 8'd39;
    localparam int KW_COUNT = 9;
    localparam int KW_MAX_LEN = 8;

    // One token as it leaves the scanner.
    typedef struct packed {
        logic [5:0]  code;
        logic [31:0] value;
        logic        ident;
    } t_tok;

    // Keyword text, first character in the low byte, zero padded.
    function automatic logic [63:0] kw_text(input logic [3:0] k);
        logic [63:0] t;
        case (k)
            4'd0: t = 64'h0000_0000_7261_6863;   // char
            4'd1: t = 64'h0000_0000_6573_6C65;   // else
            4'd2: t = 64'h0000_0000_0000_6669;   // if
            4'd3: t = 64'h0000_0000_0074_6E69;   // int
            4'd4: t = 64'h0000_0000_6E69_616D;   // main
            4'd5: t = 64'h0074_6E69_6461_6572;   // readint
            4'd6: t = 64'h0000_0000_6469_6F76;   // void
            4'd7: t = 64'h0000_0065_6C69_6877;   // while
            4'd8: t = 64'h746E_6965_7469_7277;   // writeint
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] n;
        case (k)
            4'd0: n = 4'd4;
            4'd1: n = 4'd4;
            4'd2: n = 4'd2;
            4'd3: n = 4'd3;
            4'd4: n = 4'd4;
            4'd5: n = 4'd7;
            4'd6: n = 4'd4;
            4'd7: n = 4'd5;
            4'd8: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = is_digit(c) ? (c - 8'd48) : (c - 8'd55);
        return d[3:0];
    endfunction

endpackage

// File: rtl/core/cst_scan.sv
// Scanner core of the character stream tokenizer: state machine, number,
// identifier and line registers. Produces up to two tokens per byte. Uses cst_pkg.
module cst_scan import cst_pkg::*; #(
    parameter int MAX_IDENT_CHARS = 15,
    parameter int MAX_HEX_DIGITS = 8,
    parameter int LINE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output t_tok                  o_tok0,
    output logic                  o_has0,
    output t_tok                  o_tok1,
    output logic                  o_has1,
    output logic [LINE_BITS-1:0]  o_line,
    output logic [4:0]            o_ident_count,
    output logic [8*MAX_IDENT_CHARS-1:0] o_ident_buf,
    output logic                  o_halted
);
    localparam int CW = $clog2(MAX_IDENT_CHARS + 2);
    localparam int HW = $clog2(MAX_HEX_DIGITS + 1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    logic [4:0]            r_state, n_state;
    logic [LINE_BITS-1:0]  r_line, n_line;
    logic [31:0]           r_acc, n_acc;
    logic [HW-1:0]         r_hcnt, n_hcnt;
    logic [7:0]            r_buf [MAX_IDENT_CHARS];
    logic [CW-1:0]         r_icnt, n_icnt;
    logic [7:0]            r_held, n_held;
    logic                  r_halt, n_halt;
    logic                  wr_buf;
    logic [CW-1:0]         wr_idx;

    logic [3:0] kw_hit;
    logic       kw_found;
    logic [8*KW_MAX_LEN-1:0] buf_low;
    logic       redo;

    // Keyword compare against the first eight buffered characters.
    always_comb begin
        buf_low = '0;
        for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (i < MAX_IDENT_CHARS && CW'(i) < r_icnt) begin
                buf_low[8*i +: 8] = r_buf[i];
            end
        end
        kw_hit = 4'd0;
        kw_found = 1'b0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (r_icnt == CW'(kw_len(4'(k))) && buf_low == kw_text(4'(k))) begin
                kw_hit = 4'(k);
                kw_found = 1'b1;
            end
        end
    end

    // Next-state logic: the pending state first, then a restart from idle.
    always_comb begin
        logic [5:0] ic;
        logic       ie;
        logic [4:0] ist;
        n_state = r_state;
        n_line = r_line;
        n_acc = r_acc;
        n_hcnt = r_hcnt;
        n_icnt = r_icnt;
        n_held = r_held;
        n_halt = r_halt;
        wr_buf = 1'b0;
        wr_idx = '0;
        o_tok0 = '0;
        o_has0 = 1'b0;
        o_tok1 = '0;
        o_has1 = 1'b0;
        redo = 1'b0;
        ic = TK_ERROR;
        ie = 1'b0;
        ist = ST_IDLE;

        case (r_state)
            ST_EQ: begin
                o_has0 = 1'b1;
                n_state = ST_IDLE;
                if (i_byte == "=") o_tok0.code = TK_EQ;
                else begin o_tok0.code = TK_ASSIGN; redo = 1'b1; end
            end
            ST_GT: begin
                o_has0 = 1'b1;
                n_state = ST_IDLE;
                if (i_byte == "=") o_tok0.code = TK_GE;
                else begin o_tok0.code = TK_GT; redo = 1'b1; end
            end
            ST_LT: begin
                o_has0 = 1'b1;
                n_state = ST_IDLE;
                if (i_byte == "=") o_tok0.code = TK_LE;
                else begin o_tok0.code = TK_LT; redo = 1'b1; end
            end
            ST_BANG: begin
                o_has0 = 1'b1;
                n_state = ST_IDLE;
                if (i_byte == "=") o_tok0.code = TK_NE;
                else begin o_tok0.code = TK_ERROR; n_halt = 1'b1; end
            end
            ST_AMP: begin
                o_has0 = 1'b1;
                n_state = ST_IDLE;
                if (i_byte == "&") o_tok0.code = TK_ANDAND;
                else begin o_tok0.code = TK_ERROR; n_halt = 1'b1; end
            end
            ST_BAR: begin
                o_has0 = 1'b1;
                n_state = ST_IDLE;
                if (i_byte == "|") o_tok0.code = TK_OROR;
                else begin o_tok0.code = TK_ERROR; n_halt = 1'b1; end
            end
            ST_SLASH: begin
                if (i_byte == "*") n_state = ST_BLOCK;
                else if (i_byte == "/") n_state = ST_LINE;
                else begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_SLASH;
                    n_state = ST_IDLE;
                    redo = 1'b1;
                end
            end
            ST_BLOCK, ST_BSTAR: begin
                if (i_byte == 8'd0) begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_ERROR;
                    n_halt = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_state == ST_BSTAR && i_byte == "/") begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_COMMENT;
                    n_state = ST_IDLE;
                end else begin
                    if (i_byte == 8'd10 && r_line != LINE_MAX) n_line = r_line + 1'b1;
                    n_state = (i_byte == "*") ? ST_BSTAR : ST_BLOCK;
                end
            end
            ST_LINE: begin
                if (i_byte == 8'd0) begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_ERROR;
                    n_halt = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_byte == 8'd10) begin
                    if (r_line != LINE_MAX) n_line = r_line + 1'b1;
                    o_has0 = 1'b1;
                    o_tok0.code = TK_COMMENT;
                    n_state = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (i_byte == "x") n_state = ST_HEX0;
                else begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_ERROR;
                    n_halt = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_HEX0: begin
                if (!is_hex(i_byte)) begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_ERROR;
                    n_halt = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_acc = {28'd0, hex_val(i_byte)};
                    n_hcnt = HW'(1);
                    n_state = ST_HEXN;
                end
            end
            ST_HEXN: begin
                if (is_hex(i_byte)) begin
                    if (r_hcnt >= HW'(MAX_HEX_DIGITS)) begin
                        o_has0 = 1'b1;
                        o_tok0.code = TK_ERROR;
                        n_halt = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_acc = {r_acc[27:0], hex_val(i_byte)};
                        n_hcnt = r_hcnt + 1'b1;
                    end
                end else begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_HEX;
                    o_tok0.value = r_acc;
                    n_state = ST_IDLE;
                    redo = 1'b1;
                end
            end
            ST_IDENT: begin
                if (is_alpha(i_byte) || is_digit(i_byte)) begin
                    if (r_icnt < CW'(MAX_IDENT_CHARS)) begin
                        wr_buf = 1'b1;
                        wr_idx = r_icnt;
                    end
                    if (r_icnt <= CW'(MAX_IDENT_CHARS)) n_icnt = r_icnt + 1'b1;
                end else if (r_icnt > CW'(MAX_IDENT_CHARS)) begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_ERROR;
                    n_halt = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_has0 = 1'b1;
                    o_tok0.code = kw_found ? (TK_KW_BASE + {2'b00, kw_hit}) : TK_IDENT;
                    o_tok0.ident = 1'b1;
                    n_state = ST_IDLE;
                    redo = 1'b1;
                end
            end
            ST_CH1: begin
                if (i_byte == 8'd0 || i_byte == 8'd10) begin
                    o_has0 = 1'b1;
                    o_tok0.code = TK_ERROR;
                    n_halt = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_held = i_byte;
                    n_state = ST_CH2;
                end
            end
            ST_CH2: begin
                o_has0 = 1'b1;
                n_state = ST_IDLE;
                if (i_byte == CH_QUOTE) begin
                    o_tok0.code = TK_CHAR;
                    o_tok0.value = {24'd0, r_held};
                end else begin
                    o_tok0.code = TK_ERROR;
                    n_halt = 1'b1;
                end
            end
            default: redo = 1'b1;
        endcase

        // Idle decode, either for the idle state or for a restarted byte.
        if (redo) begin
            ic = TK_ERROR;
            ie = 1'b0;
            ist = ST_IDLE;
            case (i_byte)
                " ", 8'd13, 8'd9: ;
                8'd10: if (r_line != LINE_MAX) n_line = r_line + 1'b1;
                8'd0: begin ic = TK_EOS; ie = 1'b1; end
                "(": begin ic = TK_LPAREN; ie = 1'b1; end
                ")": begin ic = TK_RPAREN; ie = 1'b1; end
                "{": begin ic = TK_LBRACE; ie = 1'b1; end
                "}": begin ic = TK_RBRACE; ie = 1'b1; end
                ";": begin ic = TK_SEMI; ie = 1'b1; end
                ",": begin ic = TK_COMMA; ie = 1'b1; end
                "+": begin ic = TK_PLUS; ie = 1'b1; end
                "-": begin ic = TK_MINUS; ie = 1'b1; end
                "*": begin ic = TK_STAR; ie = 1'b1; end
                "=": ist = ST_EQ;
                "!": ist = ST_BANG;
                ">": ist = ST_GT;
                "<": ist = ST_LT;
                "&": ist = ST_AMP;
                "|": ist = ST_BAR;
                "/": ist = ST_SLASH;
                CH_QUOTE: ist = ST_CH1;
                "0": ist = ST_ZERO;
                default: begin
                    if (is_alpha(i_byte)) begin
                        wr_buf = 1'b1;
                        wr_idx = '0;
                        n_icnt = CW'(1);
                        ist = ST_IDENT;
                    end else begin
                        ic = TK_ERROR;
                        ie = 1'b1;
                        n_halt = 1'b1;
                    end
                end
            endcase
            n_state = ist;
            if (ie) begin
                if (o_has0) begin
                    o_has1 = 1'b1;
                    o_tok1.code = ic;
                end else begin
                    o_has0 = 1'b1;
                    o_tok0.code = ic;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_line <= LINE_BITS'(1);
            r_acc <= '0;
            r_hcnt <= '0;
            r_icnt <= '0;
            r_held <= '0;
            r_halt <= 1'b0;
        end else if (i_step && !r_halt) begin
            r_state <= n_state;
            r_line <= n_line;
            r_acc <= n_acc;
            r_hcnt <= n_hcnt;
            r_icnt <= n_icnt;
            r_held <= n_held;
            r_halt <= n_halt;
        end
    end

    // Identifier buffer, written one character per byte.
    always_ff @(posedge i_clk) begin
        if (i_step && !r_halt && wr_buf) begin
            r_buf[wr_idx[$clog2(MAX_IDENT_CHARS)-1:0]] <= i_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_IDENT_CHARS; i++) o_ident_buf[8*i +: 8] = r_buf[i];
    end

    // The line reported with a token is the count after the token's last
    // character. A restarted byte only moves the count when it is a newline,
    // which makes no token, so the first token keeps the old count.
    assign o_line = redo ? r_line : n_line;
    assign o_ident_count = 5'(r_icnt);
    assign o_halted = r_halt;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt flag cleared without reset");
    a_halt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_halt) |-> r_state == ST_IDLE) else $error("halted outside idle");
    a_hex_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HW'(MAX_HEX_DIGITS)) else $error("hex digit count overrun");
    a_second_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_has1 |-> o_has0) else $error("second token without first");
endmodule

// File: rtl/core/cst_out.sv
// Result stage of the character stream tokenizer: a two-entry token queue
// that holds token payloads and drives the result channel. Uses cst_pkg.
module cst_out import cst_pkg::*; #(
    parameter int MAX_IDENT_CHARS = 15,
    parameter int LINE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_tok                  i_tok0,
    input  logic                  i_has0,
    input  t_tok                  i_tok1,
    input  logic                  i_has1,
    input  logic [LINE_BITS-1:0]  i_line,
    input  logic [4:0]            i_ident_count,
    input  logic [8*MAX_IDENT_CHARS-1:0] i_ident_buf,
    input  logic                  i_stall,
    output logic                  o_room,
    output logic                  o_valid,
    output logic [5:0]            o_token_code,
    output logic [15:0]           o_line_number,
    output logic [31:0]           o_token_value,
    output logic [3:0]            o_ident_length,
    output logic [63:0]           o_ident_chars_low,
    output logic [55:0]           o_ident_chars_high,
    output logic                  o_last_of_run
);
    typedef struct packed {
        logic [5:0]   code;
        logic [15:0]  line;
        logic [31:0]  value;
        logic [3:0]   len;
        logic [119:0] chars;
        logic         last;
    } t_res;

    t_res       r_q [2];
    logic [1:0] r_cnt;
    logic       r_head;
    t_res       e0, e1;
    logic       pop;
    logic [1:0] npush;

    // Build result entries; identifier text is masked to its length.
    always_comb begin
        logic [4:0]   len;
        logic [119:0] ch;
        len = (i_ident_count > 5'd15) ? 5'd15 : i_ident_count;
        ch = '0;
        for (int i = 0; i < 15; i++) begin
            if (i < MAX_IDENT_CHARS && 5'(i) < len) ch[8*i +: 8] = i_ident_buf[8*i +: 8];
        end
        e0 = '0;
        e0.code = i_tok0.code;
        e0.line = 16'(i_line);
        e0.value = i_tok0.value;
        e0.len = i_tok0.ident ? len[3:0] : 4'd0;
        e0.chars = i_tok0.ident ? ch : '0;
        e0.last = !i_has1;
        e1 = '0;
        e1.code = i_tok1.code;
        e1.line = 16'(i_line);
        e1.value = i_tok1.value;
        e1.last = 1'b1;
    end

    assign pop = o_valid && !i_stall;
    assign npush = i_push ? (2'(i_has0) + 2'(i_has1)) : 2'd0;
    // Accept a byte only when both of its possible tokens fit.
    assign o_room = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_head <= 1'b0;
        end else begin
            r_cnt <= r_cnt - 2'(pop) + npush;
            if (pop) r_head <= !r_head;
        end
    end

    // Tokens are written after any entry still waiting.
    always_ff @(posedge i_clk) begin
        logic ws;
        ws = r_head ^ (r_cnt != 2'd0 && !pop) ^ pop;
        if (npush != 2'd0) begin
            r_q[ws] <= e0;
            if (i_has1) r_q[!ws] <= e1;
        end
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_token_code = r_q[r_head].code;
    assign o_line_number = r_q[r_head].line;
    assign o_token_value = r_q[r_head].value;
    assign o_ident_length = r_q[r_head].len;
    assign o_ident_chars_low = r_q[r_head].chars[63:0];
    assign o_ident_chars_high = r_q[r_head].chars[119:64];
    assign o_last_of_run = r_q[r_head].last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("token queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        npush != 2'd0 |-> o_room) else $error("push without room");
    a_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> o_valid) else $error("full queue not valid");
endmodule

// File: rtl/core/character_stream_tokenizer.sv
// Top level of the character stream tokenizer; instantiates cst_scan and cst_out.
// Uses cst_pkg.
//
// One source byte is taken per cycle while the queue has room, and scanned in that cycle;
// its zero, one or two tokens go into a two-entry result queue, one token leaving per
// cycle while the receiver does not stall. A byte is taken while the queue has room for
// two tokens, so a steady stream runs at one byte per cycle except that a byte making
// two tokens holds off the next byte until a token has left the queue. After an error
// token all later bytes are taken and dropped until reset.
module character_stream_tokenizer import cst_pkg::*; #(
    parameter int MAX_IDENT_CHARS = 15,
    parameter int MAX_HEX_DIGITS = 8,
    parameter int LINE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_token_code,
    output logic [15:0] o_line_number,
    output logic [31:0] o_token_value,
    output logic [3:0]  o_ident_length,
    output logic [63:0] o_ident_chars_low,
    output logic [55:0] o_ident_chars_high,
    output logic        o_last_of_run
);
    t_tok tok0, tok1;
    logic has0, has1, room, halted, step;
    logic [LINE_BITS-1:0] line;
    logic [4:0] icnt;
    logic [8*MAX_IDENT_CHARS-1:0] ibuf;

    assign o_stall = !room;
    assign step = i_valid && room;

    cst_scan #(
        .MAX_IDENT_CHARS(MAX_IDENT_CHARS),
        .MAX_HEX_DIGITS(MAX_HEX_DIGITS),
        .LINE_BITS(LINE_BITS)
    ) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_byte(i_source_byte),
        .o_tok0(tok0), .o_has0(has0), .o_tok1(tok1), .o_has1(has1),
        .o_line(line), .o_ident_count(icnt), .o_ident_buf(ibuf), .o_halted(halted)
    );

    cst_out #(
        .MAX_IDENT_CHARS(MAX_IDENT_CHARS),
        .LINE_BITS(LINE_BITS)
    ) u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(step && !halted),
        .i_tok0(tok0), .i_has0(has0), .i_tok1(tok1), .i_has1(has1),
        .i_line(line), .i_ident_count(icnt), .i_ident_buf(ibuf),
        .i_stall(i_stall), .o_room(room), .o_valid(o_valid),
        .o_token_code(o_token_code), .o_line_number(o_line_number),
        .o_token_value(o_token_value), .o_ident_length(o_ident_length),
        .o_ident_chars_low(o_ident_chars_low), .o_ident_chars_high(o_ident_chars_high),
        .o_last_of_run(o_last_of_run)
    );
endmodule

// File: dv/character_stream_tokenizer_tb.sv
// Self-checking testbench for character_stream_tokenizer: source bytes in, tokens out.
// Uses cst_pkg for token and scanner codes; needs nothing but the RTL.
module character_stream_tokenizer_tb;
    import cst_pkg::*;

    // One token as the scanner should report it.
    typedef struct {
        logic [5:0]  code;
        logic [15:0] line;
        logic [31:0] value;
        logic [3:0]  len;
        logic [63:0] chars_lo;
        logic [55:0] chars_hi;
        logic        last;
    } token_t;

    // One source byte of stimulus, with its pacing hints.
    typedef struct {
        logic [7:0] b;
        bit         burst;
        bit         pause;
    } src_byte_t;

    // Directed rows: a byte and, where obvious, the last token it must make.
    typedef struct {
        logic [7:0] b;
        logic [5:0] code;
        bit         chk;
    } dir_row_t;

    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_source_byte = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_token_code;
    logic [15:0] o_line_number;
    logic [31:0] o_token_value;
    logic [3:0]  o_ident_length;
    logic [63:0] o_ident_chars_low;
    logic [55:0] o_ident_chars_high;
    logic        o_last_of_run;

    character_stream_tokenizer DUT (.*);

    // Scanner mirror used to predict tokens.
    logic [4:0]  scan;
    int          line_cnt;
    logic [31:0] hex_acc;
    int          hex_cnt;
    logic [7:0]  id_buf[15];
    int          id_cnt;
    logic [7:0]  held_char;
    bit          halted;
    int          produced;

    token_t      pending_tokens[$];
    src_byte_t   source_text[$];
    string       keywords[9] = '{"char", "else", "if", "int", "main", "readint", "void",
                                 "while", "writeint"};
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          tokens_checked = 0;

    dir_row_t dir_rows[25] = '{
        '{8'd0, TK_EOS, 1'b1}, '{"(", TK_LPAREN, 1'b1}, '{")", TK_RPAREN, 1'b1},
        '{"{", TK_LBRACE, 1'b1}, '{"}", TK_RBRACE, 1'b1}, '{";", TK_SEMI, 1'b1},
        '{",", TK_COMMA, 1'b1}, '{"+", TK_PLUS, 1'b1}, '{"-", TK_MINUS, 1'b1},
        '{"*", TK_STAR, 1'b1}, '{8'd10, TK_ERROR, 1'b0}, '{"=", TK_ERROR, 1'b0},
        '{";", TK_SEMI, 1'b1}, '{"=", TK_ERROR, 1'b0}, '{"=", TK_EQ, 1'b1},
        '{"!", TK_ERROR, 1'b0}, '{"=", TK_NE, 1'b1}, '{">", TK_ERROR, 1'b0},
        '{"=", TK_GE, 1'b1}, '{"<", TK_ERROR, 1'b0}, '{"=", TK_LE, 1'b1},
        '{"&", TK_ERROR, 1'b0}, '{"&", TK_ANDAND, 1'b1}, '{"|", TK_ERROR, 1'b0},
        '{"|", TK_OROR, 1'b1}
    };

    // Clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic bit numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit hex_numeral(input logic [7:0] c);
        return numeral(c) || (c >= "A" && c <= "F");
    endfunction

    // Queue one expected token built from the current scanner state.
    task automatic add_token(input logic [5:0] code, input logic [31:0] val, input bit word);
        token_t t;
        int n;
        t = '{code, line_cnt[15:0], val, 4'd0, 64'd0, 56'd0, 1'b0};
        if (word) begin
            n = (id_cnt > 15) ? 15 : id_cnt;
            t.len = n[3:0];
            for (int i = 0; i < n; i++) begin
                if (i < 8) t.chars_lo |= 64'(id_buf[i]) << (8 * i);
                else t.chars_hi |= 56'(id_buf[i]) << (8 * (i - 8));
            end
        end
        pending_tokens.push_back(t);
        produced++;
    endtask

    task automatic error_token();
        add_token(TK_ERROR, 0, 0);
        halted = 1;
        scan = ST_IDLE;
    endtask

    task automatic plain_token(input logic [5:0] code);
        add_token(code, 0, 0);
        scan = ST_IDLE;
    endtask

    task automatic bump_line();
        if (line_cnt < 65535) line_cnt++;
    endtask

    // A byte seen between tokens.
    task automatic start_token(input logic [7:0] c);
        scan = ST_IDLE;
        case (c)
            " ", 8'd13, 8'd9: ;
            8'd10: bump_line();
            8'd0: plain_token(TK_EOS);
            "(": plain_token(TK_LPAREN);
            ")": plain_token(TK_RPAREN);
            "{": plain_token(TK_LBRACE);
            "}": plain_token(TK_RBRACE);
            ";": plain_token(TK_SEMI);
            ",": plain_token(TK_COMMA);
            "+": plain_token(TK_PLUS);
            "-": plain_token(TK_MINUS);
            "*": plain_token(TK_STAR);
            "=": scan = ST_EQ;
            "!": scan = ST_BANG;
            ">": scan = ST_GT;
            "<": scan = ST_LT;
            "&": scan = ST_AMP;
            "|": scan = ST_BAR;
            "/": scan = ST_SLASH;
            CH_QUOTE: scan = ST_CH1;
            "0": scan = ST_ZERO;
            default: begin
                if (letter(c)) begin
                    id_buf[0] = c;
                    id_cnt = 1;
                    scan = ST_IDENT;
                end else begin
                    error_token();
                end
            end
        endcase
    endtask

    // Predict the tokens of one accepted byte.
    task automatic predict_tokens(input logic [7:0] c);
        bit again;
        bit hit;
        int k;
        produced = 0;
        again = 0;
        if (halted) return;
        case (scan)
            ST_EQ: if (c == "=") plain_token(TK_EQ); else begin plain_token(TK_ASSIGN); again = 1; end
            ST_GT: if (c == "=") plain_token(TK_GE); else begin plain_token(TK_GT); again = 1; end
            ST_LT: if (c == "=") plain_token(TK_LE); else begin plain_token(TK_LT); again = 1; end
            ST_BANG: if (c == "=") plain_token(TK_NE); else error_token();
            ST_AMP: if (c == "&") plain_token(TK_ANDAND); else error_token();
            ST_BAR: if (c == "|") plain_token(TK_OROR); else error_token();
            ST_SLASH: begin
                if (c == "*") scan = ST_BLOCK;
                else if (c == "/") scan = ST_LINE;
                else begin plain_token(TK_SLASH); again = 1; end
            end
            ST_BLOCK, ST_BSTAR: begin
                if (c == 0) error_token();
                else if (scan == ST_BSTAR && c == "/") plain_token(TK_COMMENT);
                else begin
                    if (c == 8'd10) bump_line();
                    scan = (c == "*") ? ST_BSTAR : ST_BLOCK;
                end
            end
            ST_LINE: begin
                if (c == 0) error_token();
                else if (c == 8'd10) begin bump_line(); plain_token(TK_COMMENT); end
            end
            ST_ZERO: if (c == "x") scan = ST_HEX0; else error_token();
            ST_HEX0: begin
                if (!hex_numeral(c)) error_token();
                else begin
                    hex_acc = numeral(c) ? 32'(c - "0") : 32'(c - "A" + 10);
                    hex_cnt = 1;
                    scan = ST_HEXN;
                end
            end
            ST_HEXN: begin
                if (hex_numeral(c)) begin
                    if (hex_cnt >= 8) error_token();
                    else begin
                        hex_acc = (hex_acc << 4) | (numeral(c) ? 32'(c - "0") : 32'(c - "A" + 10));
                        hex_cnt++;
                    end
                end else begin
                    add_token(TK_HEX, hex_acc, 0);
                    scan = ST_IDLE;
                    again = 1;
                end
            end
            ST_IDENT: begin
                if (letter(c) || numeral(c)) begin
                    if (id_cnt < 15) id_buf[id_cnt] = c;
                    if (id_cnt <= 15) id_cnt++;
                end else if (id_cnt > 15) begin
                    error_token();
                end else begin
                    // Keywords are identifiers that match the table exactly.
                    for (k = 0; k < 9; k++) begin
                        hit = (keywords[k].len() == id_cnt);
                        for (int i = 0; i < id_cnt && hit; i++)
                            if (id_buf[i] != keywords[k][i]) hit = 0;
                        if (hit) break;
                    end
                    add_token((k < 9) ? TK_KW_BASE + 6'(k) : TK_IDENT, 0, 1);
                    scan = ST_IDLE;
                    again = 1;
                end
            end
            ST_CH1: begin
                if (c == 0 || c == 8'd10) error_token();
                else begin held_char = c; scan = ST_CH2; end
            end
            ST_CH2: begin
                if (c == CH_QUOTE) begin add_token(TK_CHAR, 32'(held_char), 0); scan = ST_IDLE; end
                else error_token();
            end
            default: start_token(c);
        endcase
        if (again && !halted) start_token(c);
        if (produced > 0) pending_tokens[$].last = 1;
    endtask

    function automatic void put_byte(input logic [7:0] b, input bit burst = 0,
                                     input bit pause = 0);
        source_text.push_back('{b, burst, pause});
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic logic [7:0] any_letter();
        int r;
        r = $urandom_range(0, 52);
        return (r < 26) ? 8'("A" + r) : (r < 52) ? 8'("a" + r - 26) : 8'("_");
    endfunction

    function automatic logic [7:0] word_char();
        return ($urandom_range(0, 4) == 0) ? 8'("0" + $urandom_range(0, 9)) : any_letter();
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789ABCDEF";
        return digits[$urandom_range(0, 15)];
    endfunction

    // One well-formed token with random content; returns 1 when it stays open.
    function automatic bit put_token();
        string seps;
        logic [7:0] b;
        int n;
        case ($urandom_range(0, 11))
            0, 1: begin seps = "(){};,+-*"; put_byte(seps[$urandom_range(0, 8)]); return 0; end
            2: begin
                case ($urandom_range(0, 5))
                    0: put_text("=="); 1: put_text("!="); 2: put_text(">=");
                    3: put_text("<="); 4: put_text("&&"); default: put_text("||");
                endcase
                return 0;
            end
            3: begin seps = "=></"; put_byte(seps[$urandom_range(0, 3)]); return 1; end
            4: begin
                put_text("0x");
                n = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(1, 8);
                repeat (n) put_byte(hex_char());
                return 1;
            end
            5, 6: begin
                n = ($urandom_range(0, 5) == 0) ? 15 : $urandom_range(1, 15);
                put_byte(any_letter());
                repeat (n - 1) put_byte(word_char());
                return 1;
            end
            7: begin put_text(keywords[$urandom_range(0, 8)]); return 1; end
            8: begin
                b = $urandom_range(1, 255);
                put_byte(CH_QUOTE);
                put_byte(b == 8'd10 ? 8'd11 : b);
                put_byte(CH_QUOTE);
                return 0;
            end
            9: begin
                // Block comment: no slash inside, closed by a run of stars.
                put_text("/*");
                repeat ($urandom_range(0, 12)) begin
                    b = $urandom_range(1, 255);
                    put_byte(b == "/" ? 8'("*") : b);
                end
                repeat ($urandom_range(1, 3)) put_byte("*");
                put_byte("/");
                return 0;
            end
            10: begin
                put_text("//");
                repeat ($urandom_range(0, 12)) begin
                    b = $urandom_range(1, 255);
                    put_byte(b == 8'd10 ? 8'("q") : b);
                end
                put_byte(8'd10);
                return 0;
            end
            default: begin put_byte(8'd0); return 0; end
        endcase
    endfunction

    // The one error sequence that ends the run, followed by ignored noise.
    task automatic put_error();
        case ($urandom_range(0, 11))
            0: put_byte(($urandom_range(0, 1) == 1) ? 8'($urandom_range(128, 255)) : 8'("7"));
            1: put_text("!a");
            2: put_text("0y");
            3: put_text("0xg");
            4: begin put_text("0x"); repeat (9) put_byte(hex_char()); end
            5: begin put_byte(any_letter()); repeat (15) put_byte(word_char()); put_byte(" "); end
            6: begin put_byte(CH_QUOTE); put_byte(8'd10); end
            7: begin put_byte(CH_QUOTE); put_text("ab"); end
            8: begin put_text("/*"); put_byte(8'd0); end
            9: begin put_text("//"); put_byte(8'd0); end
            10: put_text("& ");
            default: put_text("| ");
        endcase
        repeat (8) put_byte($urandom_range(0, 255));
    endtask

    // Compare one delivered token with the oldest prediction.
    task automatic check_token();
        token_t t;
        if (pending_tokens.size() == 0) begin
            $error("unexpected token: code %0d", o_token_code);
            fail_count++;
            return;
        end
        t = pending_tokens.pop_front();
        tokens_checked++;
        if (o_token_code !== t.code) begin
            $error("token_code: expected %0d, got %0d", t.code, o_token_code); fail_count++;
        end
        if (o_line_number !== t.line) begin
            $error("line_number: expected %0d, got %0d", t.line, o_line_number); fail_count++;
        end
        if (o_token_value !== t.value) begin
            $error("token_value: expected %h, got %h", t.value, o_token_value); fail_count++;
        end
        if (o_ident_length !== t.len) begin
            $error("ident_length: expected %0d, got %0d", t.len, o_ident_length); fail_count++;
        end
        if (o_ident_chars_low !== t.chars_lo) begin
            $error("ident_chars_low: expected %h, got %h", t.chars_lo, o_ident_chars_low);
            fail_count++;
        end
        if (o_ident_chars_high !== t.chars_hi) begin
            $error("ident_chars_high: expected %h, got %h", t.chars_hi, o_ident_chars_high);
            fail_count++;
        end
        if (o_last_of_run !== t.last) begin
            $error("last_of_run: expected %0d, got %0d", t.last, o_last_of_run); fail_count++;
        end
    endtask

    // Token receiver: random stalls, one long hold-off to back the block up.
    initial begin
        int wait_cycles;
        int received;
        received = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (received == 150) wait_cycles = LONG_HOLD;
            else if ($urandom_range(0, 2) == 0) wait_cycles = 0;
            else wait_cycles = $urandom_range(0, 17);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_valid !== 1'b1);
            check_token();
            received++;
        end
    end

    // Stimulus, source byte sender and end of run.
    initial begin
        int gap;
        int idx;
        bit open_token;
        string seps;
        src_byte_t s;

        scan = ST_IDLE; line_cnt = 1; hex_acc = 0; hex_cnt = 0;
        id_cnt = 0; held_char = 0; halted = 0;
        foreach (id_buf[i]) id_buf[i] = '0;

        // Random source text; an open token always gets a closing separator.
        seps = " \t\r\n;(),+-{}";
        while (source_text.size() < 1100) begin
            if (source_text.size() > 500 && source_text.size() < 520) begin
                source_text[$].pause = 0;
            end
            open_token = put_token();
            if (open_token) put_byte(seps[$urandom_range(0, seps.len() - 1)]);
            else repeat ($urandom_range(0, 2)) put_byte(($urandom_range(0, 3) == 0) ? 8'd10 : " ");
            if (idx == 0 && source_text.size() > 550) begin
                put_byte(" ", 0, 1);
                idx = 1;
            end
        end
        put_byte(" ");
        put_error();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < $size(dir_rows) + source_text.size(); r++) begin
            if (r < $size(dir_rows)) s = '{dir_rows[r].b, 0, 0};
            else s = source_text[r - $size(dir_rows)];
            if (s.pause) begin
                i_valid <= 1'b0;
                while (pending_tokens.size() != 0) @(posedge i_clk);
                repeat (4) @(posedge i_clk);
            end
            gap = (s.burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_source_byte <= s.b;
            do @(posedge i_clk); while (o_stall === 1'b1);
            predict_tokens(s.b);
            bytes_sent++;
            if (r < $size(dir_rows) && dir_rows[r].chk &&
                    (produced == 0 || pending_tokens[$].code != dir_rows[r].code)) begin
                $error("directed byte %0d: token_code expected %0d", r, dir_rows[r].code);
                fail_count++;
            end
        end
        i_valid <= 1'b0;

        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Tokenizer run: %0d source bytes, %0d tokens checked, line count %0d.",
                 bytes_sent, tokens_checked, line_cnt);
        $display("Covered every token kind, a full queue under back-pressure, a drained pause",
                 " and the halt on error.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
